>>> rtl/core/dense_matrix_vector_product_macros.svh
// Assertion macros used by the RTL of the dense matrix-vector product.
`ifndef DENSE_MATRIX_VECTOR_PRODUCT_MACROS_SVH
`define DENSE_MATRIX_VECTOR_PRODUCT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DMVP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define DMVP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

>>> rtl/core/dmvp_pkg.sv
`default_nettype none

package dmvp_pkg;

    localparam int DIM_W   = 5;
    localparam int IDX_W   = 4;
    localparam int DATA_W  = 32;
    localparam int PROD_W  = 2 * DATA_W;
    // Up to 16 exact products, plus a sign bit of headroom.
    localparam int ACC_W   = PROD_W + 4;
    localparam int FRAC_W  = 16;

    // Longest compute run that the row field of a result can name.
    localparam int RUN_LIMIT = 16;

    localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

    localparam logic [1:0] CMD_WR_MATRIX = 2'd0;
    localparam logic [1:0] CMD_WR_VECTOR = 2'd1;
    localparam logic [1:0] CMD_COMPUTE   = 2'd2;

    localparam logic signed [ACC_W-1:0] ACC_HALF = 68'sd32768;
    localparam logic signed [ACC_W-1:0] ACC_QMAX = 68'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_QMIN = -68'sd2147483648;

    typedef struct packed {
        logic [1:0]               command;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         column_index;
        logic signed [DATA_W-1:0] entry_value;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0]         result_row;
        logic signed [DATA_W-1:0] product_value;
        logic                     saturated;
        logic                     last_row;
    } t_out_word;

    // Tag that travels with each operand pair through the store and the MAC.
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage

`default_nettype wire

>>> rtl/core/dmvp_store.sv
`default_nettype none

module dmvp_store #(
    parameter int MAX_DIM = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_mat_we,
    input  wire [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] i_mat_waddr,
    input  wire                         i_vec_we,
    input  wire [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] i_vec_waddr,
    input  wire [dmvp_pkg::DATA_W-1:0]  i_wdata,
    input  dmvp_pkg::t_mac_ctl          i_rd_ctl,
    input  wire [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] i_mat_raddr,
    input  wire [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] i_vec_raddr,
    output dmvp_pkg::t_mac_ctl          o_rd_ctl,
    output logic [dmvp_pkg::DATA_W-1:0] o_mat_data,
    output logic [dmvp_pkg::DATA_W-1:0] o_vec_data
);
    import dmvp_pkg::*;

    localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;

    logic [DATA_W-1:0] r_mat [MAT_DEPTH];
    logic [DATA_W-1:0] r_vec [MAX_DIM];
    logic [DATA_W-1:0] r_mat_rd;
    logic [DATA_W-1:0] r_vec_rd;
    t_mac_ctl          r_ctl;

    always_ff @(posedge i_clk) begin
        if (i_mat_we) begin
            r_mat[i_mat_waddr] <= i_wdata;
        end
        r_mat_rd <= r_mat[i_mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_vec_we) begin
            r_vec[i_vec_waddr] <= i_wdata;
        end
        r_vec_rd <= r_vec[i_vec_raddr];
    end

    // The tag is registered alongside the reads, so it arrives together with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_rd_ctl;
        end
    end

    assign o_rd_ctl   = r_ctl;
    assign o_mat_data = r_mat_rd;
    assign o_vec_data = r_vec_rd;

endmodule

`default_nettype wire

>>> rtl/core/dmvp_mac.sv
`default_nettype none

module dmvp_mac (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  dmvp_pkg::t_mac_ctl                 i_ctl,
    input  wire signed [dmvp_pkg::DATA_W-1:0]  i_mat_data,
    input  wire signed [dmvp_pkg::DATA_W-1:0]  i_vec_data,
    output logic                               o_res_valid,
    output logic signed [dmvp_pkg::DATA_W-1:0] o_res_value,
    output logic                               o_res_sat
);
    import dmvp_pkg::*;

    t_mac_ctl                 r_prod_ctl;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic                     r_acc_done;
    logic signed [ACC_W-1:0]  w_round;
    logic                     r_res_valid;
    logic signed [DATA_W-1:0] r_res_value;
    logic                     r_res_sat;

    // Stage 1: exact Q32.32 product.
    always_ff @(posedge i_clk) begin
        r_prod <= i_mat_data * i_vec_data;
    end

    // Stage 2: exact running sum over the row.
    always_comb begin
        n_acc = (r_prod_ctl.first ? '0 : r_acc) + ACC_W'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (r_prod_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    // Stage 3: round half up to Q16.16, then clip to 32 bits.
    assign w_round = (r_acc + ACC_HALF) >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (w_round > ACC_QMAX) begin
            r_res_value <= DATA_W'(ACC_QMAX);
            r_res_sat   <= 1'b1;
        end else if (w_round < ACC_QMIN) begin
            r_res_value <= DATA_W'(ACC_QMIN);
            r_res_sat   <= 1'b1;
        end else begin
            r_res_value <= w_round[DATA_W-1:0];
            r_res_sat   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_ctl  <= '0;
            r_acc_done  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_prod_ctl  <= i_ctl;
            r_acc_done  <= r_prod_ctl.valid && r_prod_ctl.last;
            r_res_valid <= r_acc_done;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res_value = r_res_value;
    assign o_res_sat   = r_res_sat;

endmodule

`default_nettype wire

>>> rtl/core/dense_matrix_vector_product.sv
// Dense matrix-vector product over signed Q16.16 values.
//
// Input words arrive on i_in_valid / o_in_stall / i_in_word. A write-matrix word stores
// one entry at (row_index, column_index), a write-vector word stores one vector entry
// at column_index; both are taken one per cycle while no compute run is in progress and
// give no output. A compute word produces one output word per row in use, rows 0 upward,
// on o_out_valid / i_out_stall / o_out_word. Each carries the row's exact dot product,
// rounded half up and clipped to Q16.16 with a saturation flag; the final row of the run
// carries last_row. The dimension register (i_cfg_we / i_cfg_wdata) sets the rows and
// columns in use; zero acts as one and values above the smaller of the store size and 16
// act as that smaller value. One shared multiply-accumulate unit walks the stored matrix:
// each row's reads pass through the store read register and the MAC pipeline into the
// output register; a compute word keeps o_in_stall high until the last row's result lands.
// A new row starts only once the output register is empty or being taken, so a
// stall on the output pauses the walk and no word is ever dropped.
// Synchronous reset clears the control state and sets the dimension to 16; the stores
// keep their contents, and entries read by a compute run must have been written first.

`default_nettype none

`include "dense_matrix_vector_product_macros.svh"

module dense_matrix_vector_product #(
    parameter int MAX_DIM = 16
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  dmvp_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output dmvp_pkg::t_out_word             o_out_word,
    input  wire                             i_cfg_we,
    input  wire [dmvp_pkg::DIM_W-1:0]       i_cfg_wdata
);
    import dmvp_pkg::*;

    localparam int MAT_AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int VEC_AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    // Longest run: the store size, but no more than the row field can name.
    localparam int RUN_MAX = (MAX_DIM < RUN_LIMIT) ? MAX_DIM : RUN_LIMIT;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LAUNCH,
        S_ISSUE,
        S_WAIT
    } t_state;

    t_state             r_state;
    logic [DIM_W-1:0]   r_dimension;
    logic [IDX_W-1:0]   r_row;
    logic [IDX_W-1:0]   r_col;
    logic [IDX_W-1:0]   r_last_idx;
    logic [IDX_W-1:0]   n_last_idx;
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic               w_in_take;
    logic               w_slot_free;
    logic               w_issue;
    logic               w_mat_we;
    logic               w_vec_we;
    logic [MAT_AW-1:0]  w_mat_waddr;
    logic [MAT_AW-1:0]  w_mat_raddr;
    t_mac_ctl           w_rd_ctl;
    t_mac_ctl           w_mac_ctl;
    logic [DATA_W-1:0]  w_mat_data;
    logic [DATA_W-1:0]  w_vec_data;
    logic               w_res_valid;
    logic signed [DATA_W-1:0] w_res_value;
    logic               w_res_sat;

    // Words are taken only while the sequencer is idle.
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_take  = i_in_valid && (r_state == S_IDLE);

    // The output register is free when empty or when its word leaves this cycle.
    assign w_slot_free = !r_out_valid || !i_out_stall;

    // Last row and column index of the run, taken from the dimension register.
    always_comb begin
        if (r_dimension == '0) begin
            n_last_idx = '0;
        end else if (r_dimension > DIM_W'(RUN_MAX)) begin
            n_last_idx = IDX_W'(RUN_MAX - 1);
        end else begin
            n_last_idx = IDX_W'(r_dimension - 1'b1);
        end
    end

    // Load writes go straight to the stores; out-of-range positions are dropped.
    assign w_mat_we = w_in_take && (i_in_word.command == CMD_WR_MATRIX)
                      && (32'(i_in_word.row_index) < MAX_DIM)
                      && (32'(i_in_word.column_index) < MAX_DIM);
    assign w_vec_we = w_in_take && (i_in_word.command == CMD_WR_VECTOR)
                      && (32'(i_in_word.column_index) < MAX_DIM);
    assign w_mat_waddr = MAT_AW'(32'(i_in_word.row_index) * MAX_DIM
                                 + 32'(i_in_word.column_index));

    // One operand pair is read per cycle while a row is being walked.
    assign w_issue = ((r_state == S_LAUNCH) && w_slot_free) || (r_state == S_ISSUE);
    assign w_mat_raddr = MAT_AW'(32'(r_row) * MAX_DIM + 32'(r_col));

    always_comb begin
        w_rd_ctl.valid = w_issue;
        w_rd_ctl.first = (r_col == '0);
        w_rd_ctl.last  = (r_col == r_last_idx);
    end

    dmvp_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mat_we    (w_mat_we),
        .i_mat_waddr (w_mat_waddr),
        .i_vec_we    (w_vec_we),
        .i_vec_waddr (VEC_AW'(i_in_word.column_index)),
        .i_wdata     (i_in_word.entry_value),
        .i_rd_ctl    (w_rd_ctl),
        .i_mat_raddr (w_mat_raddr),
        .i_vec_raddr (VEC_AW'(r_col)),
        .o_rd_ctl    (w_mac_ctl),
        .o_mat_data  (w_mat_data),
        .o_vec_data  (w_vec_data)
    );

    dmvp_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_mac_ctl),
        .i_mat_data  (w_mat_data),
        .i_vec_data  (w_vec_data),
        .o_res_valid (w_res_valid),
        .o_res_value (w_res_value),
        .o_res_sat   (w_res_sat)
    );

    // Sequencer: launch a row when the output slot is free, issue its columns,
    // then wait for the row's result to land in the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dimension <= DIM_RESET;
            r_row       <= '0;
            r_col       <= '0;
            r_last_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dimension <= i_cfg_wdata;
            end

            if (w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_in_take && (i_in_word.command == CMD_COMPUTE)) begin
                        r_row      <= '0;
                        r_col      <= '0;
                        r_last_idx <= n_last_idx;
                        r_state    <= S_LAUNCH;
                    end
                end
                S_LAUNCH: begin
                    if (w_slot_free) begin
                        if (r_last_idx == '0) begin
                            r_state <= S_WAIT;
                        end else begin
                            r_col   <= r_col + 1'b1;
                            r_state <= S_ISSUE;
                        end
                    end
                end
                S_ISSUE: begin
                    if (r_col == r_last_idx) begin
                        r_col   <= '0;
                        r_state <= S_WAIT;
                    end else begin
                        r_col <= r_col + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (w_res_valid) begin
                        if (r_row == r_last_idx) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_col   <= '0;
                            r_state <= S_LAUNCH;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output payload; the row counter still names the row whose result arrives.
    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_word.result_row    <= r_row;
            r_out_word.product_value <= w_res_value;
            r_out_word.saturated     <= w_res_sat;
            r_out_word.last_row      <= (r_row == r_last_idx);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `DMVP_ASSERT(a_res_in_wait, w_res_valid |-> (r_state == S_WAIT), "result outside wait state")
    `DMVP_ASSERT(a_res_slot_free, w_res_valid |-> !r_out_valid, "result overwrites pending word")
    `DMVP_ASSERT(a_last_idle, (r_out_valid && r_out_word.last_row) |->
        (r_state == S_IDLE || r_state == S_LAUNCH), "run still active after last row")
    `DMVP_ASSERT(a_row_bound, (r_state != S_IDLE) |-> (r_row <= r_last_idx), "row counter beyond run")
    `DMVP_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

`default_nettype wire
